// File: rtl/alarm_clock_controller_assert.svh
// ----------------------------------------------------------------------------
// Alarm clock controller assertion macros
// These are concurrent assertion wrappers that compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef ALARM_CLOCK_CONTROLLER_ASSERT_SVH
`define ALARM_CLOCK_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS

`define ACC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ACC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ACC_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define ACC_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/alclk_pkg.sv
// ----------------------------------------------------------------------------
// Alarm clock controller package
// This package holds the request and result types, the configuration type and the operation codes.
// ----------------------------------------------------------------------------
package alclk_pkg;

    localparam int RING_COUNTER_BITS_DEF = 16;

    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_BLINK_PERIOD = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RING_LIMIT   = 4'd1;

    localparam logic [7:0]  BLINK_PERIOD_RST = 8'd200;
    localparam logic [15:0] RING_LIMIT_RST   = 16'd60000;

    localparam logic [2:0] OP_TICK       = 3'd0;
    localparam logic [2:0] OP_KEY        = 3'd1;
    localparam logic [2:0] OP_RTC_MATCH  = 3'd2;
    localparam logic [2:0] OP_ENTER_MENU = 3'd3;
    localparam logic [2:0] OP_TOGGLE_DAY = 3'd4;

    localparam logic [1:0] BTN_ONE   = 2'd0;
    localparam logic [1:0] BTN_TWO   = 2'd1;
    localparam logic [1:0] BTN_THREE = 2'd2;

    localparam logic [1:0] MENU_ENABLE = 2'd0;
    localparam logic [1:0] MENU_HOUR   = 2'd1;
    localparam logic [1:0] MENU_MINUTE = 2'd2;

    localparam logic [4:0] HOUR_MAX    = 5'd23;
    localparam logic [5:0] MINUTE_MAX  = 6'd59;
    localparam logic [2:0] DAY_MAX     = 3'd6;
    localparam logic [2:0] DAY_NONE    = 3'd7;
    localparam logic [2:0] DAY_MONDAY  = 3'd1;

    typedef struct packed {
        logic [2:0] opcode;
        logic [1:0] button;
        logic [2:0] weekday;
    } req_t;

    typedef struct packed {
        logic       ringing;
        logic       led_on;
        logic       alarm_on;
        logic [4:0] wake_hour;
        logic [5:0] alarm_minute;
        logic [6:0] day_mask;
        logic [1:0] menu_field;
        logic [2:0] selected_day;
        logic       save_request;
    } res_t;

    typedef struct packed {
        logic [7:0]  blink_period;
        logic [15:0] ring_limit;
    } cfg_t;

endpackage

// File: rtl/alclk_cfg_regs.sv
// ----------------------------------------------------------------------------
// Alarm clock configuration registers
// This module holds the blink period and the ring limit, written through the configuration port.
// ----------------------------------------------------------------------------
module alclk_cfg_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [alclk_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [alclk_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output alclk_pkg::cfg_t                      cfg
);

    alclk_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.blink_period <= alclk_pkg::BLINK_PERIOD_RST;
            cfg_reg.ring_limit   <= alclk_pkg::RING_LIMIT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                alclk_pkg::CFG_BLINK_PERIOD: begin
                    cfg_reg.blink_period <= cfg_data[7:0];
                end
                alclk_pkg::CFG_RING_LIMIT: begin
                    cfg_reg.ring_limit <= cfg_data[15:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: rtl/alclk_in_reg.sv
// ----------------------------------------------------------------------------
// Alarm clock input register
// This module registers one request and holds it until the core takes it.
// ----------------------------------------------------------------------------
module alclk_in_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  alclk_pkg::req_t s_req,
    input  logic            take,
    output logic            in_vld,
    output alclk_pkg::req_t in_q
);

    logic            vld_reg;
    alclk_pkg::req_t req_reg;

    assign s_ready = !vld_reg || take;
    assign in_vld  = vld_reg;
    assign in_q    = req_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_ready) begin
            vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_req;
        end
    end

endmodule

// File: rtl/alclk_core.sv
// ----------------------------------------------------------------------------
// Alarm clock core
// This module holds the alarm state and computes its update and the result for one request.
// ----------------------------------------------------------------------------
module alclk_core #(
    parameter int RING_COUNTER_BITS = alclk_pkg::RING_COUNTER_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  alclk_pkg::cfg_t cfg,
    input  logic            fire,
    input  alclk_pkg::req_t item,
    output alclk_pkg::res_t res
);

    localparam int CMP_BITS = (RING_COUNTER_BITS > 16) ? RING_COUNTER_BITS : 16;

    logic                         alarm_on_reg, alarm_on_next;
    logic [4:0]                   hour_reg, hour_next;
    logic [5:0]                   minute_reg, minute_next;
    logic [6:0]                   day_bits_reg, day_bits_next;
    logic [1:0]                   menu_reg, menu_next;
    logic [2:0]                   chosen_day_reg, chosen_day_next;
    logic                         ring_flag_reg, ring_flag_next;
    logic [RING_COUNTER_BITS-1:0] ring_count_reg, ring_count_next;
    logic [7:0]                   blink_count_reg, blink_count_next;
    logic                         led_reg, led_next;
    logic                         save;

    logic                         ring_active;
    logic [7:0]                   blink_inc;
    logic [2:0]                   chosen_mod;
    logic [6:0]                   chosen_mask;
    logic [6:0]                   weekday_mask;

    assign ring_active  = ring_flag_reg &&
                          (CMP_BITS'(ring_count_reg) < CMP_BITS'(cfg.ring_limit));
    assign blink_inc    = blink_count_reg + 8'd1;
    assign chosen_mod   = (chosen_day_reg == alclk_pkg::DAY_NONE) ? 3'd0 : chosen_day_reg;
    assign chosen_mask  = 7'd1 << chosen_mod;
    assign weekday_mask = 7'd1 << item.weekday;

    always_comb begin
        alarm_on_next    = alarm_on_reg;
        hour_next        = hour_reg;
        minute_next      = minute_reg;
        day_bits_next    = day_bits_reg;
        menu_next        = menu_reg;
        chosen_day_next  = chosen_day_reg;
        ring_flag_next   = ring_flag_reg;
        ring_count_next  = ring_count_reg;
        blink_count_next = blink_count_reg;
        led_next         = led_reg;
        save             = 1'b0;
        case (item.opcode)
            alclk_pkg::OP_TICK: begin
                if (ring_active) begin
                    if (blink_inc >= cfg.blink_period) begin
                        blink_count_next = 8'd0;
                        led_next         = !led_reg;
                    end else begin
                        blink_count_next = blink_inc;
                    end
                    ring_count_next = ring_count_reg + 1'b1;
                end else begin
                    led_next         = 1'b0;
                    ring_flag_next   = 1'b0;
                    ring_count_next  = '0;
                    blink_count_next = 8'd0;
                end
            end
            alclk_pkg::OP_KEY: begin
                if (ring_flag_reg && item.button == alclk_pkg::BTN_ONE) begin
                    ring_flag_next = 1'b0;
                    led_next       = 1'b0;
                end else if (item.button == alclk_pkg::BTN_THREE) begin
                    menu_next = menu_reg + 2'd1;
                end else begin
                    case (menu_reg)
                        alclk_pkg::MENU_ENABLE: begin
                            if (item.button == alclk_pkg::BTN_TWO) begin
                                alarm_on_next = !alarm_on_reg;
                                save          = 1'b1;
                            end
                        end
                        alclk_pkg::MENU_HOUR: begin
                            if (item.button == alclk_pkg::BTN_TWO) begin
                                hour_next = (hour_reg >= alclk_pkg::HOUR_MAX) ? 5'd0
                                                                              : hour_reg + 5'd1;
                                save      = 1'b1;
                            end
                        end
                        alclk_pkg::MENU_MINUTE: begin
                            if (item.button == alclk_pkg::BTN_TWO) begin
                                minute_next = (minute_reg >= alclk_pkg::MINUTE_MAX) ? 6'd0
                                                                : minute_reg + 6'd1;
                                save        = 1'b1;
                            end
                        end
                        default: begin
                            if (item.button == alclk_pkg::BTN_ONE) begin
                                chosen_day_next = (chosen_day_reg >= alclk_pkg::DAY_MAX) ? 3'd0
                                                                : chosen_day_reg + 3'd1;
                            end else if (item.button == alclk_pkg::BTN_TWO) begin
                                day_bits_next = day_bits_reg ^ chosen_mask;
                                save          = 1'b1;
                            end
                        end
                    endcase
                end
            end
            alclk_pkg::OP_RTC_MATCH: begin
                ring_flag_next = alarm_on_reg && (|(day_bits_reg & weekday_mask));
            end
            alclk_pkg::OP_ENTER_MENU: begin
                menu_next       = alclk_pkg::MENU_ENABLE;
                chosen_day_next = alclk_pkg::DAY_MONDAY;
            end
            alclk_pkg::OP_TOGGLE_DAY: begin
                day_bits_next = day_bits_reg ^ weekday_mask;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res.ringing      = ring_flag_next;
        res.led_on       = led_next;
        res.alarm_on     = alarm_on_next;
        res.wake_hour    = hour_next;
        res.alarm_minute = minute_next;
        res.day_mask     = day_bits_next;
        res.menu_field   = menu_next;
        res.selected_day = chosen_day_next;
        res.save_request = save;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alarm_on_reg    <= 1'b0;
            hour_reg        <= 5'd0;
            minute_reg      <= 6'd0;
            day_bits_reg    <= 7'd0;
            menu_reg        <= alclk_pkg::MENU_ENABLE;
            chosen_day_reg  <= alclk_pkg::DAY_MONDAY;
            ring_flag_reg   <= 1'b0;
            ring_count_reg  <= '0;
            blink_count_reg <= 8'd0;
            led_reg         <= 1'b0;
        end else if (fire) begin
            alarm_on_reg    <= alarm_on_next;
            hour_reg        <= hour_next;
            minute_reg      <= minute_next;
            day_bits_reg    <= day_bits_next;
            menu_reg        <= menu_next;
            chosen_day_reg  <= chosen_day_next;
            ring_flag_reg   <= ring_flag_next;
            ring_count_reg  <= ring_count_next;
            blink_count_reg <= blink_count_next;
            led_reg         <= led_next;
        end
    end

endmodule

// File: rtl/alclk_out_reg.sv
// ----------------------------------------------------------------------------
// Alarm clock result register
// This module holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module alclk_out_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            fire,
    input  alclk_pkg::res_t res,
    output logic            take,
    output logic            m_valid,
    input  logic            m_ready,
    output alclk_pkg::res_t m_res
);

    logic            vld_reg;
    alclk_pkg::res_t res_reg;

    assign take    = !vld_reg || m_ready;
    assign m_valid = vld_reg;
    assign m_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (take) begin
            vld_reg <= fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res;
        end
    end

endmodule

// File: rtl/alarm_clock_controller.sv
// ----------------------------------------------------------------------------
// Alarm clock controller
// This block keeps the alarm settings, the menu and the ringing state, and answers every request
// with one result that shows the state after that request.
//
//   Channel   Ports                          Direction  Content
//   request   s_valid s_ready s_req          in         opcode, button, weekday
//   result    m_valid m_ready m_res          out        state after the request
//   config    cfg_valid cfg_ready cfg_index  in         blink period, ring limit
//             cfg_data
//
// A request waits in the input register until the core takes it; its result then goes to the
// result register. Both registers advance together, so one request is taken in every cycle while
// m_ready is high. The configuration port is always ready. Reset is synchronous and active low
// and resets the valid flags, the configuration and the core state. When m_ready is low, the
// result register holds, and the input register takes one more request before s_ready falls.
// ----------------------------------------------------------------------------
`include "alarm_clock_controller_assert.svh"

module alarm_clock_controller #(
    parameter int RING_COUNTER_BITS = alclk_pkg::RING_COUNTER_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  alclk_pkg::req_t                      s_req,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output alclk_pkg::res_t                      m_res,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [alclk_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [alclk_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    alclk_pkg::cfg_t cfg;
    alclk_pkg::req_t in_q;
    alclk_pkg::res_t res;
    logic            in_vld;
    logic            take;
    logic            fire;

    assign fire = in_vld && take;

    alclk_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    alclk_in_reg u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .take    (take),
        .in_vld  (in_vld),
        .in_q    (in_q)
    );

    alclk_core #(
        .RING_COUNTER_BITS (RING_COUNTER_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .fire    (fire),
        .item    (in_q),
        .res     (res)
    );

    alclk_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .res     (res),
        .take    (take),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    `ACC_ASSERT_NXT(a_fire_loads_result, aclk, aresetn, fire, m_valid)
    `ACC_ASSERT_NXT(a_stalled_request_holds, aclk, aresetn, in_vld && !fire, in_vld && $stable(in_q))
    `ACC_ASSERT_IMP(a_full_blocks_request, aclk, aresetn, in_vld && m_valid && !m_ready, !s_ready)

endmodule
